// File: rtl/engine_start_sequencer_core_defines.svh
// assertion macros for the engine start sequencer checker
// depends on nothing; included by files that carry assertions
`ifndef ENGINE_START_SEQUENCER_CORE_DEFINES_SVH
`define ENGINE_START_SEQUENCER_CORE_DEFINES_SVH

// implication checked at every clock edge outside reset
`define ESSEQ_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// implication with the consequent checked in the cycle after the antecedent
`define ESSEQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/esseq_pkg.sv
// shared types and constants of the engine start sequencer
// depends on nothing
package esseq_pkg;

  // engine mode codes
  typedef enum logic [1:0] {
    MODE_OFF   = 2'd0,
    MODE_IGN   = 2'd1,
    MODE_START = 2'd2,
    MODE_RUN   = 2'd3
  } mode_t;

  // controller states
  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_MUL  = 2'd1,
    ST_DIV  = 2'd2,
    ST_DONE = 2'd3
  } ctrl_state_t;

  // configuration register indexes
  localparam int CfgIdxW = 3;
  localparam int CfgDataW = 16;
  localparam logic [CfgIdxW-1:0] REG_CENTER_LEVEL  = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_RC_HALF_SPAN  = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_SERVO_MIN     = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_SERVO_MAX     = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_IDLE_ANGLE    = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_CRANK_TIMEOUT = 3'd5;

  // divider geometry: 20-bit dividend magnitude, four bits per cycle
  localparam int DivW = 20;
  localparam int DivStepsPerCycle = 4;
  localparam int DivCycles = DivW / DivStepsPerCycle;
  localparam int DivCntW = $clog2(DivCycles);

  // update word
  typedef struct packed {
    logic        opcode;
    logic [10:0] ignition_channel;
    logic [10:0] starter_channel;
    logic [10:0] throttle_channel;
    logic [31:0] now_ms;
  } upd_word_t;

  // result word
  typedef struct packed {
    logic       ignition_relay;
    logic       starter_relay;
    logic [7:0] servo_angle;
    logic [1:0] engine_mode;
  } res_word_t;

  // controller to datapath commands
  typedef struct packed {
    logic load;
    logic mul;
    logic div_step;
    logic finish;
  } esseq_cmd_t;

endpackage

// File: rtl/esseq_ctrl.sv
// controller of the engine start sequencer: handshakes and step sequencing
// depends on esseq_pkg
module esseq_ctrl
  import esseq_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       upd_valid,
  output logic       upd_stall,
  output logic       res_valid,
  input  logic       res_stall,
  output esseq_cmd_t cmd
);

  ctrl_state_t          state;
  ctrl_state_t          state_next;
  logic [DivCntW-1:0]   div_cnt;
  logic                 out_free;

  // output register can take a word when empty or being drained
  assign out_free = !res_valid || !res_stall;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (upd_valid) state_next = ST_MUL;
      ST_MUL:  state_next = ST_DIV;
      ST_DIV:  if (div_cnt == DivCntW'(DivCycles - 1)) state_next = ST_DONE;
      ST_DONE: if (out_free) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // commands and stall
  always_comb begin
    cmd = '0;
    upd_stall = 1'b1;
    case (state)
      ST_IDLE: begin
        upd_stall = 1'b0;
        cmd.load = upd_valid;
      end
      ST_MUL:  cmd.mul = 1'b1;
      ST_DIV:  cmd.div_step = 1'b1;
      ST_DONE: cmd.finish = out_free;
      default: cmd = '0;
    endcase
  end

  // state, divider cycle count and result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      div_cnt <= '0;
      res_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.mul) begin
        div_cnt <= '0;
      end else if (cmd.div_step) begin
        div_cnt <= div_cnt + 1'b1;
      end
      if (cmd.finish) begin
        res_valid <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
    end
  end

endmodule

// File: rtl/esseq_dp.sv
// datapath of the engine start sequencer: config, mode state, throttle scaling
// depends on esseq_pkg
module esseq_dp
  import esseq_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  esseq_cmd_t          cmd,
  input  upd_word_t           upd_word,
  input  logic                cfg_valid,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_data,
  output res_word_t           res_word
);

  // configuration registers
  logic [10:0] center_level;
  logic [9:0]  rc_half_span;
  logic [7:0]  servo_min_angle;
  logic [7:0]  servo_max_angle;
  logic [7:0]  idle_angle;
  logic [15:0] crank_timeout_ms;

  // sequencer state
  mode_t       mode;
  mode_t       mode_next;
  logic        crank_lock;
  logic        crank_lock_next;
  logic [31:0] crank_start_time;
  logic [31:0] crank_start_time_next;
  logic        use_map;
  logic        use_map_next;
  logic [10:0] thr_ch;

  // scaling and divider
  logic signed [12:0] dev;
  logic signed [8:0]  span;
  logic signed [21:0] prod;
  logic [21:0]        prod_mag;
  logic [10:0]        den;
  logic [DivW-1:0]    div_q;
  logic [10:0]        div_r;
  logic               div_neg;
  logic [DivW-1:0]    div_q_next;
  logic [10:0]        div_r_next;
  logic [DivW-1:0]    quo;
  logic signed [DivW:0] q_signed;
  logic signed [DivW:0] lo;
  logic signed [DivW:0] hi;
  logic [7:0]         mapped;
  logic               ign_on;
  logic               st_on;
  logic [31:0]        elapsed;

  // config writes, unlisted indexes ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      center_level <= 11'd1500;
      rc_half_span <= 10'd500;
      servo_min_angle <= 8'd0;
      servo_max_angle <= 8'd180;
      idle_angle <= 8'd0;
      crank_timeout_ms <= 16'd3000;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_CENTER_LEVEL:  center_level <= cfg_data[10:0];
        REG_RC_HALF_SPAN:  rc_half_span <= cfg_data[9:0];
        REG_SERVO_MIN:     servo_min_angle <= cfg_data[7:0];
        REG_SERVO_MAX:     servo_max_angle <= cfg_data[7:0];
        REG_IDLE_ANGLE:    idle_angle <= cfg_data[7:0];
        REG_CRANK_TIMEOUT: crank_timeout_ms <= cfg_data;
        default: ;
      endcase
    end
  end

  // mode transitions for the incoming word
  assign ign_on = upd_word.ignition_channel > center_level;
  assign st_on = upd_word.starter_channel > center_level;
  assign elapsed = upd_word.now_ms - crank_start_time;

  always_comb begin
    mode_next = mode;
    crank_lock_next = crank_lock;
    crank_start_time_next = crank_start_time;
    use_map_next = 1'b0;
    if (upd_word.opcode) begin
      mode_next = MODE_OFF;
      crank_lock_next = 1'b0;
    end else begin
      case (mode)
        MODE_OFF: begin
          crank_lock_next = 1'b0;
          if (ign_on) mode_next = MODE_IGN;
        end
        MODE_IGN: begin
          if (!ign_on) begin
            mode_next = MODE_OFF;
          end else if (st_on && !crank_lock) begin
            crank_start_time_next = upd_word.now_ms;
            crank_lock_next = 1'b1;
            mode_next = MODE_START;
          end
        end
        MODE_START: begin
          if (elapsed >= {16'd0, crank_timeout_ms} || !st_on) mode_next = MODE_RUN;
        end
        MODE_RUN: begin
          if (!ign_on) begin
            mode_next = MODE_OFF;
          end else if (!st_on) begin
            use_map_next = 1'b1;
          end
        end
        default: mode_next = MODE_OFF;
      endcase
      if (!st_on && mode_next != MODE_START) crank_lock_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_OFF;
      crank_lock <= 1'b0;
      crank_start_time <= '0;
      use_map <= 1'b0;
    end else if (cmd.load) begin
      mode <= mode_next;
      crank_lock <= crank_lock_next;
      crank_start_time <= crank_start_time_next;
      use_map <= use_map_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) thr_ch <= upd_word.throttle_channel;
  end

  // scaled numerator: offset channel times angle span
  assign dev = $signed({2'b00, thr_ch}) - $signed({2'b00, center_level})
             + $signed({3'b000, rc_half_span});
  assign span = $signed({1'b0, servo_max_angle}) - $signed({1'b0, servo_min_angle});
  assign prod = 22'(dev) * 22'(span);
  assign prod_mag = prod[21] ? 22'(-prod) : prod;
  assign den = {rc_half_span, 1'b0};

  // restoring division, several quotient bits per cycle
  always_comb begin
    logic [11:0]     sh;
    logic [10:0]     rr;
    logic [DivW-1:0] qq;
    rr = div_r;
    qq = div_q;
    for (int i = 0; i < DivStepsPerCycle; i++) begin
      sh = {rr, qq[DivW-1]};
      qq = {qq[DivW-2:0], 1'b0};
      if (sh >= {1'b0, den}) begin
        sh = sh - {1'b0, den};
        qq[0] = 1'b1;
      end
      rr = sh[10:0];
    end
    div_q_next = qq;
    div_r_next = rr;
  end

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      div_q <= prod_mag[DivW-1:0];
      div_r <= '0;
      div_neg <= prod[21];
    end else if (cmd.div_step) begin
      div_q <= div_q_next;
      div_r <= div_r_next;
    end
  end

  // signed quotient, zero half span gives zero, then clamp
  assign quo = (rc_half_span == '0) ? '0 : div_q;
  assign q_signed = div_neg ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
  assign lo = $signed({13'd0, servo_min_angle});
  assign hi = $signed({13'd0, servo_max_angle});

  always_comb begin
    if (q_signed < lo) begin
      mapped = servo_min_angle;
    end else if (q_signed > hi) begin
      mapped = servo_max_angle;
    end else begin
      mapped = q_signed[7:0];
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      res_word.ignition_relay <= (mode != MODE_OFF);
      res_word.starter_relay <= (mode == MODE_START);
      res_word.servo_angle <= use_map ? mapped : idle_angle;
      res_word.engine_mode <= mode;
    end
  end

endmodule

// File: rtl/engine_start_sequencer_core.sv
// engine start sequencer top level: controller plus datapath
// depends on esseq_pkg, esseq_ctrl, esseq_dp
//
// Usage:
//   upd channel: one update word (opcode, three RC channels, ms time) is
//   taken at an edge with upd_valid high and upd_stall low.
//   res channel: one result word (relays, servo angle, mode) per update,
//   taken at an edge with res_valid high and res_stall low.
//   cfg channel: register writes by index, always ready; write only while
//   no update is in flight.
//   After an update is taken the controller steps through the multiply,
//   divide (divider for throttle scaling, four quotient bits per cycle) and
//   done states before res_valid rises; no new update enters meanwhile.
//   The output register lets a new update enter while a result waits.
//   If the receiver stalls a second finished result, the block holds it and
//   keeps upd_stall high until the output register frees.
//   Reset (rst, synchronous): mode off, crank lock clear, crank start time
//   zero, registers at their default values, no result pending.
module engine_start_sequencer_core
  import esseq_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                upd_valid,
  output logic                upd_stall,
  input  upd_word_t           upd_word,
  output logic                res_valid,
  input  logic                res_stall,
  output res_word_t           res_word,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_data
);

  esseq_cmd_t cmd;

  // config writes are always accepted and registered
  assign cfg_ready = 1'b1;

  // step sequencing and handshakes
  esseq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .upd_valid (upd_valid),
    .upd_stall (upd_stall),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .cmd       (cmd)
  );

  // state, scaling and result register
  esseq_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .upd_word  (upd_word),
    .cfg_valid (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .res_word  (res_word)
  );

endmodule

// File: rtl/esseq_checker.sv
// port-level checks of the engine start sequencer, bound to the top level
// depends on esseq_pkg and engine_start_sequencer_core_defines.svh
`include "engine_start_sequencer_core_defines.svh"

module esseq_checker
  import esseq_pkg::*;
(
  input logic      clk,
  input logic      rst,
  input logic      upd_valid,
  input logic      upd_stall,
  input logic      res_valid,
  input logic      res_stall,
  input res_word_t res_word
);

  logic starter_match;
  logic ignition_match;
  logic res_held;

  // relay bits as the reported mode implies
  assign starter_match = res_word.starter_relay == (res_word.engine_mode == MODE_START);
  assign ignition_match = res_word.ignition_relay == (res_word.engine_mode != MODE_OFF);
  assign res_held = res_valid && res_stall;

  // starter relay only while starting
  `ESSEQ_ASSERT_IMP(a_starter_mode, res_valid, starter_match, "starter relay does not match mode")

  // ignition relay whenever the engine is not off
  `ESSEQ_ASSERT_IMP(a_ignition_mode, res_valid, ignition_match, "ignition relay does not match mode")

  // one update at a time: busy right after a word is taken
  `ESSEQ_ASSERT_NEXT(a_busy_after_take, upd_valid && !upd_stall, upd_stall, "update taken while busy")

  // a stalled result holds
  `ESSEQ_ASSERT_NEXT(a_res_hold, res_held, res_valid && $stable(res_word), "stalled result changed")

endmodule

bind engine_start_sequencer_core esseq_checker u_esseq_checker (.*);
